FILE: design/srta_pkg.sv
// Shared constants, command/status types and digit lookup for the signed radix-to-text block.
package srta_pkg;

  localparam int unsigned SRTA_MAX_BASE_DEF = 16;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned DIGIT_SLOTS = 16;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned TBL_W       = DIGIT_SLOTS * CHAR_W;

  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned STK_IDX_W   = 5;

  localparam int unsigned DIV_BITS    = 8;
  localparam int unsigned DIV_STEPS   = VALUE_W / DIV_BITS;
  localparam int unsigned STEP_W      = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN    = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic div;
    logic emit;
  } srta_cmd_t;

  typedef struct packed {
    logic base_ok;
    logic div_done;
    logic out_free;
    logic emit_last;
  } srta_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [TBL_W-1:0] tbl,
                                                   input logic [SLOT_W-1:0] d);
    return tbl[{d, 3'b000} +: CHAR_W];
  endfunction

endpackage

FILE: design/srta_if.sv
// Valid/ready stream interfaces for the value input and the character output.
interface srta_in_if import srta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srta_out_if import srta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: design/signed_radix_to_ascii_top.sv
// Top level of the signed radix-to-text converter.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       value[31:0] signed
//   out_ch   out  valid/ready       character[7:0], last
//   cfg_*    in   cfg_we only       cfg_index[1:0], cfg_wdata[63:0]
//
// One value at a time: an accept state, a base check state, then the divider for each
// digit (8 quotient bits per cycle over the 32-bit magnitude), then the characters
// one by one while the output register drains.
// Reset (rst_n low, synchronous) clears the configuration to an invalid base.
// A stalled output holds the emission phase; the input is not taken until the
// final character of the previous value has been registered.
module signed_radix_to_ascii_top import srta_pkg::*; #(
  parameter int unsigned MAX_BASE = SRTA_MAX_BASE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  srta_in_if.sink               in_ch,
  srta_out_if.source            out_ch
);

  localparam int unsigned RAD_W = $clog2(MAX_BASE + 1);

  srta_cmd_t          cmd;
  srta_sts_t          sts;
  logic [TBL_W-1:0]   tbl;
  logic [RAD_W-1:0]   radix;
  logic               in_ready;

  srta_cfg #(.MAX_BASE(MAX_BASE)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tbl       (tbl),
    .base_ok   (sts.base_ok),
    .radix     (radix)
  );

  srta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  srta_dp #(.MAX_BASE(MAX_BASE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_ch.value),
    .tbl           (tbl),
    .radix         (radix),
    .out_ready     (out_ch.ready),
    .div_done      (sts.div_done),
    .out_free      (sts.out_free),
    .emit_last     (sts.emit_last),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a word is in progress");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("character emitted over an untaken output word");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> in_ch.ready)
    else $error("input not reopened after the final character");

  a_no_emit_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div && cmd.emit))
    else $error("emission overlaps division");

endmodule

FILE: design/srta_cfg.sv
// Configuration registers and digit table validity check.
module srta_cfg import srta_pkg::*; #(
  parameter int unsigned MAX_BASE = SRTA_MAX_BASE_DEF,
  localparam int unsigned RAD_W   = $clog2(MAX_BASE + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [TBL_W-1:0]      tbl,
  output logic                  base_ok,
  output logic [RAD_W-1:0]      radix
);

  logic [CFG_DATA_W-1:0] low_r;
  logic [CFG_DATA_W-1:0] high_r;
  logic [LEN_W-1:0]      len_r;
  logic [CHAR_W-1:0]     chr [DIGIT_SLOTS];
  logic                  bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIGITS_LOW:  low_r  <= cfg_wdata;
        CFG_DIGITS_HIGH: high_r <= cfg_wdata;
        CFG_BASE_LEN:    len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign tbl = {high_r, low_r};

  for (genvar g = 0; g < DIGIT_SLOTS; g++) begin : g_chr
    assign chr[g] = tbl[g*CHAR_W +: CHAR_W];
  end

  // sign characters and repeated digits within the used slots make the base unusable
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (LEN_W'(i) < len_r) begin
        if (chr[i] == CHAR_MINUS || chr[i] == CHAR_PLUS) bad = 1'b1;
        for (int j = i + 1; j < DIGIT_SLOTS; j++) begin
          if (LEN_W'(j) < len_r && chr[i] == chr[j]) bad = 1'b1;
        end
      end
    end
  end

  assign base_ok = !bad && (len_r >= LEN_W'(2)) && (len_r <= LEN_W'(MAX_BASE));
  assign radix   = len_r[RAD_W-1:0];

endmodule

FILE: design/srta_dp.sv
// Datapath: magnitude divider, digit stack and output word register.
module srta_dp import srta_pkg::*; #(
  parameter int unsigned MAX_BASE = SRTA_MAX_BASE_DEF,
  localparam int unsigned RAD_W   = $clog2(MAX_BASE + 1),
  localparam int unsigned DIG_W   = $clog2(MAX_BASE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srta_cmd_t          cmd,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [TBL_W-1:0]   tbl,
  input  logic [RAD_W-1:0]   radix,
  input  logic               out_ready,
  output logic               div_done,
  output logic               out_free,
  output logic               emit_last,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  localparam int unsigned TRIAL_W = DIG_W + 1;

  logic [VALUE_W-1:0]  div_r;
  logic [DIG_W-1:0]    rem_r;
  logic [RAD_W-1:0]    radix_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                sign_pend_r;
  logic [DIG_W-1:0]    stk_r [MAX_DIGITS];
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic [TRIAL_W-1:0]  rad_ext;
  logic [TRIAL_W-1:0]  trial;
  logic [DIG_W-1:0]    rem_c;
  logic [DIV_BITS-1:0] qbits;
  logic [VALUE_W-1:0]  quo_c;
  logic                step_end;
  logic [STK_IDX_W-1:0] top_idx;

  assign rad_ext = TRIAL_W'(radix_r);

  // eight restoring steps: top byte of the dividend against the radix
  always_comb begin
    rem_c = rem_r;
    trial = '0;
    qbits = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_c, div_r[VALUE_W-1-k]};
      if (trial >= rad_ext) begin
        qbits[DIV_BITS-1-k] = 1'b1;
        trial = trial - rad_ext;
      end
      rem_c = trial[DIG_W-1:0];
    end
  end

  assign quo_c    = {div_r[VALUE_W-DIV_BITS-1:0], qbits};
  assign step_end = (step_r == STEP_W'(DIV_STEPS - 1));
  assign div_done = step_end && ((quo_c == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1)));
  assign top_idx  = STK_IDX_W'(cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      cnt_r       <= '0;
      sign_pend_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        sign_pend_r <= in_value[VALUE_W-1];
        cnt_r       <= '0;
      end
      if (cmd.start) begin
        step_r <= '0;
      end
      if (cmd.div) begin
        step_r <= step_r + STEP_W'(1);
        if (step_end) cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        if (sign_pend_r) sign_pend_r <= 1'b0;
        else             cnt_r       <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    end
    if (cmd.start) begin
      rem_r   <= '0;
      radix_r <= radix;
    end
    if (cmd.div) begin
      div_r <= quo_c;
      if (step_end) begin
        stk_r[cnt_r[STK_IDX_W-1:0]] <= rem_c;
        rem_r <= '0;
      end else begin
        rem_r <= rem_c;
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign emit_last = !sign_pend_r && (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (sign_pend_r) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= digit_char(tbl, SLOT_W'(stk_r[top_idx]));
        out_last_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

FILE: design/srta_ctrl.sv
// Controller state machine: accept, base check, digit division and character emission.
module srta_ctrl import srta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  srta_sts_t sts,
  output logic      in_ready,
  output srta_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // drop the word when the digit table is unusable
        if (sts.base_ok) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
